/* hw/rtl/interrupt_redirection_router_defines.svh */
// Assertion helpers shared by the router modules.
`ifndef INTERRUPT_REDIRECTION_ROUTER_DEFINES_SVH
`define INTERRUPT_REDIRECTION_ROUTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IRR_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IRR_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/irr_pkg.sv */
`timescale 1ns / 1ps

package irr_pkg;

	// Request kinds.
	localparam logic [2:0] KIND_CLEAR     = 3'd0;
	localparam logic [2:0] KIND_ADD       = 3'd1;
	localparam logic [2:0] KIND_ENABLE    = 3'd2;
	localparam logic [2:0] KIND_ROUTE_GSI = 3'd3;
	localparam logic [2:0] KIND_ROUTE_ISA = 3'd4;
	localparam logic [2:0] KIND_ROUTE_PCI = 3'd5;
	localparam logic [2:0] KIND_SET_MASK  = 3'd6;
	localparam logic [2:0] KIND_READ      = 3'd7;

	// Result status codes.
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NOT_READY = 3'd1;
	localparam logic [2:0] ST_VEC_LOW   = 3'd2;
	localparam logic [2:0] ST_RANGE     = 3'd3;
	localparam logic [2:0] ST_NO_PCI    = 3'd4;
	localparam logic [2:0] ST_FULL      = 3'd5;

	// Register index decoded from the configuration address.
	localparam logic REG_GSI_BASE    = 1'b0;
	localparam logic REG_ENTRY_COUNT = 1'b1;

	localparam logic [9:0] GSI_BASE_RESET    = 10'd0;
	localparam logic [8:0] ENTRY_COUNT_RESET = 9'd24;

	localparam logic [7:0] MIN_VECTOR    = 8'h20;
	localparam logic [7:0] MAX_PCI_LINE  = 8'd23;
	localparam logic [7:0] PCI_LINE_NONE = 8'hFF;

	// Override flag codes, used for both polarity and trigger fields.
	localparam logic [1:0] FLAG_HIGH_EDGE = 2'd1;
	localparam logic [1:0] FLAG_LOW_LEVEL = 2'd3;

	// Command queue geometry.
	localparam int Q_DEPTH = 2;
	localparam int Q_PW    = 1;
	localparam int Q_CW    = 2;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] source_irq;
		logic [9:0] gsi;
		logic [3:0] override_flags;
		logic [7:0] vector;
		logic [7:0] dest_id;
		logic       level_trigger;
		logic       active_low;
		logic       mask_on;
		logic       vec_ok;
		logic       pci_line_ok;
	} irr_cmd_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  entry_index;
		logic [16:0] entry_low;
		logic [31:0] entry_high;
		logic [9:0]  gsi_used;
	} irr_result_t;

	typedef struct packed {
		logic full;
		logic empty;
	} irr_q_status_t;

endpackage

/* hw/rtl/irr_front.sv */
`timescale 1ns / 1ps

module irr_front
	import irr_pkg::*;
(
	input  logic          start,
	output logic          busy,
	input  logic [2:0]    kind,
	input  logic [7:0]    source_irq,
	input  logic [9:0]    gsi,
	input  logic [3:0]    override_flags,
	input  logic [7:0]    vector,
	input  logic [7:0]    dest_id,
	input  logic          level_trigger,
	input  logic          active_low,
	input  logic          mask_on,
	input  irr_q_status_t q_stat,
	output logic          push,
	output irr_cmd_t      cmd
);

	// A request is taken whenever the queue has room.
	assign busy = q_stat.full;
	assign push = start && !q_stat.full;

	always_comb begin
		cmd = '0;
		cmd.kind           = kind;
		cmd.source_irq     = source_irq;
		cmd.gsi            = gsi;
		cmd.override_flags = override_flags;
		cmd.vector         = vector;
		cmd.dest_id        = dest_id;
		cmd.level_trigger  = level_trigger;
		cmd.active_low     = active_low;
		cmd.mask_on        = mask_on;
		cmd.vec_ok         = (vector >= MIN_VECTOR);
		cmd.pci_line_ok    = (source_irq != 8'd0) && (source_irq != PCI_LINE_NONE)
			&& (source_irq <= MAX_PCI_LINE);
	end

endmodule

/* hw/rtl/irr_cmd_queue.sv */
`timescale 1ns / 1ps
`include "interrupt_redirection_router_defines.svh"

module irr_cmd_queue
	import irr_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  irr_cmd_t      push_cmd,
	input  logic          pop,
	output irr_cmd_t      head,
	output irr_q_status_t q_stat
);

	irr_cmd_t              slot_q [Q_DEPTH];
	logic     [Q_PW-1:0]   wr_ptr_q;
	logic     [Q_PW-1:0]   rd_ptr_q;
	logic     [Q_CW-1:0]   cnt_q;

	assign q_stat.full  = (cnt_q == Q_CW'(Q_DEPTH));
	assign q_stat.empty = (cnt_q == '0);
	assign head         = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	`IRR_ASSERT_IMP(a_no_overflow, clk, arst_n, push, !q_stat.full || pop, "push into full queue")
	`IRR_ASSERT_IMP(a_no_underflow, clk, arst_n, pop, !q_stat.empty, "pop from empty queue")

endmodule

/* hw/rtl/irr_back.sv */
`timescale 1ns / 1ps
`include "interrupt_redirection_router_defines.svh"

module irr_back
	import irr_pkg::*;
#(
	parameter int OVERRIDE_DEPTH = 32,
	parameter int ENTRY_DEPTH    = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	input  irr_cmd_t      head,
	input  irr_q_status_t q_stat,
	output logic          pop,
	input  logic [9:0]    gsi_base,
	input  logic [8:0]    n_use,
	output logic          res_vld,
	output irr_result_t   res
);

	localparam int OCW = $clog2(OVERRIDE_DEPTH + 1);
	localparam int OIW = (OVERRIDE_DEPTH > 1) ? $clog2(OVERRIDE_DEPTH) : 1;
	localparam int EIW = (ENTRY_DEPTH > 1) ? $clog2(ENTRY_DEPTH) : 1;

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_DISPATCH = 3'd1;
	localparam logic [2:0] S_SWEEP    = 3'd2;
	localparam logic [2:0] S_SEARCH   = 3'd3;
	localparam logic [2:0] S_ROUTE    = 3'd4;
	localparam logic [2:0] S_ENT_RD   = 3'd5;
	localparam logic [2:0] S_ENT_WB   = 3'd6;

	typedef struct packed {
		logic [7:0] irq;
		logic [9:0] gsi;
		logic [3:0] flags;
	} ovr_entry_t;

	typedef struct packed {
		logic [7:0] dest;
		logic       mask;
		logic       level;
		logic       low;
		logic [7:0] vector;
	} red_entry_t;

	function automatic logic [16:0] low_word(input red_entry_t e);
		low_word = {e.mask, e.level, 1'b0, e.low, 5'b0, e.vector};
	endfunction

	function automatic logic [31:0] high_word(input red_entry_t e);
		high_word = {e.dest, 24'b0};
	endfunction

	logic [2:0]        state_q, state_d;
	irr_cmd_t          cmd_q;
	logic [OCW-1:0]    ovr_cnt_q, ovr_cnt_d;
	logic              ready_q, ready_d;
	logic [OCW-1:0]    scan_q, scan_d;
	logic              cmp_vld_q, cmp_vld_d;
	logic [9:0]        tg_q, tg_d;
	logic              level_q, level_d;
	logic              low_q, low_d;
	logic [EIW-1:0]    idx_q, idx_d;
	logic [8:0]        sweep_q, sweep_d;
	logic              res_vld_q;
	irr_result_t       res_q;
	logic              em_vld;
	irr_result_t       em_res;

	ovr_entry_t        ovr_mem [OVERRIDE_DEPTH];
	ovr_entry_t        ovr_rd_q;
	logic              ovr_we;
	ovr_entry_t        ovr_wdata;

	red_entry_t        red_mem [ENTRY_DEPTH];
	red_entry_t        red_rd_q;
	logic              red_we;
	logic [EIW-1:0]    red_waddr;
	red_entry_t        red_wdata;

	logic [9:0]        chk_g;
	logic [9:0]        chk_diff;
	logic              chk_ok;
	logic              hit;
	red_entry_t        ent;

	assign pop = (state_q == S_IDLE) && !q_stat.empty;

	// Range check of a global number against the window served by the table.
	assign chk_g    = (state_q == S_ROUTE) ? tg_q : cmd_q.gsi;
	assign chk_diff = chk_g - gsi_base;
	assign chk_ok   = (chk_g >= gsi_base) && (chk_diff < {1'b0, n_use});

	assign hit = cmp_vld_q && (ovr_rd_q.irq == cmd_q.source_irq);

	always_comb begin
		state_d   = state_q;
		ovr_cnt_d = ovr_cnt_q;
		ready_d   = ready_q;
		scan_d    = scan_q;
		cmp_vld_d = cmp_vld_q;
		tg_d      = tg_q;
		level_d   = level_q;
		low_d     = low_q;
		idx_d     = idx_q;
		sweep_d   = sweep_q;
		em_vld    = 1'b0;
		em_res    = '0;
		ovr_we    = 1'b0;
		ovr_wdata = '{irq: cmd_q.source_irq, gsi: cmd_q.gsi, flags: cmd_q.override_flags};
		red_we    = 1'b0;
		red_waddr = idx_q;
		red_wdata = '0;
		ent       = red_rd_q;

		case (state_q)
			S_IDLE: begin
				if (!q_stat.empty) begin
					state_d = S_DISPATCH;
				end
			end

			S_DISPATCH: begin
				scan_d    = '0;
				cmp_vld_d = 1'b0;
				state_d   = S_IDLE;
				case (cmd_q.kind)
					KIND_CLEAR: begin
						ovr_cnt_d = '0;
						em_vld    = 1'b1;
					end
					KIND_ADD: begin
						em_vld = 1'b1;
						if (ovr_cnt_q >= OCW'(OVERRIDE_DEPTH)) begin
							em_res.status = ST_FULL;
						end else begin
							ovr_we    = 1'b1;
							ovr_cnt_d = ovr_cnt_q + 1'b1;
						end
					end
					KIND_ENABLE: begin
						sweep_d = '0;
						state_d = S_SWEEP;
					end
					KIND_ROUTE_GSI: begin
						tg_d    = cmd_q.gsi;
						level_d = cmd_q.level_trigger;
						low_d   = cmd_q.active_low;
						state_d = S_ROUTE;
					end
					KIND_ROUTE_ISA: begin
						tg_d    = {2'b0, cmd_q.source_irq};
						level_d = 1'b0;
						low_d   = 1'b0;
						state_d = S_SEARCH;
					end
					KIND_ROUTE_PCI: begin
						if (!ready_q) begin
							em_vld        = 1'b1;
							em_res.status = ST_NOT_READY;
						end else if (!cmd_q.pci_line_ok) begin
							em_vld        = 1'b1;
							em_res.status = ST_NO_PCI;
						end else begin
							tg_d    = {2'b0, cmd_q.source_irq};
							level_d = 1'b1;
							low_d   = 1'b1;
							state_d = S_SEARCH;
						end
					end
					KIND_SET_MASK, KIND_READ: begin
						em_res.gsi_used = cmd_q.gsi;
						idx_d           = chk_diff[EIW-1:0];
						if (!ready_q) begin
							em_vld        = 1'b1;
							em_res.status = ST_NOT_READY;
						end else if (!chk_ok) begin
							em_vld        = 1'b1;
							em_res.status = ST_RANGE;
						end else begin
							state_d = S_ENT_RD;
						end
					end
					default: begin
						em_vld = 1'b1;
					end
				endcase
			end

			S_SWEEP: begin
				red_we    = 1'b1;
				red_waddr = sweep_q[EIW-1:0];
				red_wdata = '{dest: 8'd0, mask: 1'b1, level: 1'b0, low: 1'b0, vector: 8'd0};
				if (sweep_q + 9'd1 >= n_use) begin
					ready_d = 1'b1;
					em_vld  = 1'b1;
					state_d = S_IDLE;
				end else begin
					sweep_d = sweep_q + 9'd1;
				end
			end

			S_SEARCH: begin
				if (hit) begin
					tg_d = ovr_rd_q.gsi;
					if (cmd_q.kind == KIND_ROUTE_ISA) begin
						low_d   = (ovr_rd_q.flags[1:0] == FLAG_LOW_LEVEL);
						level_d = (ovr_rd_q.flags[3:2] == FLAG_LOW_LEVEL);
					end else begin
						low_d   = (ovr_rd_q.flags[1:0] != FLAG_HIGH_EDGE);
						level_d = (ovr_rd_q.flags[3:2] != FLAG_HIGH_EDGE);
					end
					state_d = S_ROUTE;
				end else if (scan_q < ovr_cnt_q) begin
					scan_d    = scan_q + 1'b1;
					cmp_vld_d = 1'b1;
				end else begin
					state_d = S_ROUTE;
				end
			end

			S_ROUTE: begin
				em_vld          = 1'b1;
				em_res.gsi_used = tg_q;
				state_d         = S_IDLE;
				if (!ready_q) begin
					em_res.status = ST_NOT_READY;
				end else if (!cmd_q.vec_ok) begin
					em_res.status = ST_VEC_LOW;
				end else if (!chk_ok) begin
					em_res.status = ST_RANGE;
				end else begin
					red_we    = 1'b1;
					red_waddr = chk_diff[EIW-1:0];
					red_wdata = '{dest: cmd_q.dest_id, mask: 1'b0, level: level_q,
						low: low_q, vector: cmd_q.vector};
					em_res.entry_index = 8'(chk_diff[EIW-1:0]);
					em_res.entry_low   = low_word(red_wdata);
					em_res.entry_high  = high_word(red_wdata);
				end
			end

			S_ENT_RD: begin
				state_d = S_ENT_WB;
			end

			S_ENT_WB: begin
				if (cmd_q.kind == KIND_SET_MASK) begin
					ent.mask  = cmd_q.mask_on;
					red_we    = 1'b1;
					red_wdata = ent;
				end
				em_vld             = 1'b1;
				em_res.entry_index = 8'(idx_q);
				em_res.entry_low   = low_word(ent);
				em_res.entry_high  = high_word(ent);
				em_res.gsi_used    = cmd_q.gsi;
				state_d            = S_IDLE;
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ovr_cnt_q <= '0;
			ready_q   <= 1'b0;
			cmp_vld_q <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			ovr_cnt_q <= ovr_cnt_d;
			ready_q   <= ready_d;
			cmp_vld_q <= cmp_vld_d;
			res_vld_q <= em_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head;
		end
		scan_q  <= scan_d;
		tg_q    <= tg_d;
		level_q <= level_d;
		low_q   <= low_d;
		idx_q   <= idx_d;
		sweep_q <= sweep_d;
		if (em_vld) begin
			res_q <= em_res;
		end
	end

	// Override table: written at the fill count, read at the scan pointer.
	always_ff @(posedge clk) begin
		if (ovr_we) begin
			ovr_mem[ovr_cnt_q[OIW-1:0]] <= ovr_wdata;
		end
		ovr_rd_q <= ovr_mem[scan_q[OIW-1:0]];
	end

	// Redirection table: one write port, one registered read at the held index.
	always_ff @(posedge clk) begin
		if (red_we) begin
			red_mem[red_waddr] <= red_wdata;
		end
		red_rd_q <= red_mem[idx_q];
	end

	assign res_vld = res_vld_q;
	assign res     = res_q;

	`IRR_ASSERT_NEXT(a_ready_sticky, clk, arst_n, ready_q, ready_q, "ready flag dropped")
	`IRR_ASSERT_NEXT(a_one_result, clk, arst_n, res_vld_q, !res_vld_q, "back to back results")
	`IRR_ASSERT_IMP(a_ovr_bound, clk, arst_n, ovr_we, ovr_cnt_q < OCW'(OVERRIDE_DEPTH),
		"override write past table end")

endmodule

/* hw/rtl/interrupt_redirection_router.sv */
`timescale 1ns / 1ps
// Channel   | Handshake                          | Payload
// ----------+------------------------------------+--------------------------------------
// command   | start, busy (taken: start & !busy) | kind, source_irq, gsi, override_flags,
//           |                                    | vector, dest_id, level_trigger,
//           |                                    | active_low, mask_on
// result    | done (one-cycle strobe)            | status, entry_index, entry_low,
//           |                                    | entry_high, gsi_used
// config    | psel, penable, pwrite, pready      | paddr, pwdata, prdata
//
// A command transfer lands in a two-entry queue; the engine takes one command at a time.
// Routes write their entry, after an override search for the ISA and PCI lookups;
// enable masks each entry in use in turn; mask and read fetch the entry, and mask writes it back.
// busy is high only while the queue holds two commands; results cannot be stalled.
// arst_n clears the queue, the engine, the override count and the ready flag, loads
// gsi_base with 0 and entry_count with 24; both tables start undefined.

module interrupt_redirection_router
	import irr_pkg::*;
#(
	parameter int OVERRIDE_DEPTH = 32,
	parameter int ENTRY_DEPTH    = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  kind,
	input  logic [7:0]  source_irq,
	input  logic [9:0]  gsi,
	input  logic [3:0]  override_flags,
	input  logic [7:0]  vector,
	input  logic [7:0]  dest_id,
	input  logic        level_trigger,
	input  logic        active_low,
	input  logic        mask_on,
	output logic        done,
	output logic [2:0]  status,
	output logic [7:0]  entry_index,
	output logic [16:0] entry_low,
	output logic [31:0] entry_high,
	output logic [9:0]  gsi_used,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [9:0]    gsi_base_q;
	logic [8:0]    entry_count_q;
	logic [8:0]    n_use;
	logic          cfg_wr;
	logic          push;
	logic          pop;
	irr_cmd_t      push_cmd;
	irr_cmd_t      head;
	irr_q_status_t q_stat;
	irr_result_t   res;

	// The register port never inserts wait states. Register index is address bit 2.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gsi_base_q    <= GSI_BASE_RESET;
			entry_count_q <= ENTRY_COUNT_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_GSI_BASE:    gsi_base_q    <= pwdata[9:0];
				REG_ENTRY_COUNT: entry_count_q <= pwdata[8:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_GSI_BASE:    prdata = {22'b0, gsi_base_q};
			REG_ENTRY_COUNT: prdata = {23'b0, entry_count_q};
			default:         prdata = '0;
		endcase
	end

	// A count of zero, or any count beyond the table, means the whole table.
	assign n_use = ((entry_count_q == 9'd0) || (entry_count_q > 9'(ENTRY_DEPTH)))
		? 9'(ENTRY_DEPTH) : entry_count_q;

	// Front end: takes the command transfer and precomputes the cheap checks.
	irr_front u_front (
		.start          (start),
		.busy           (busy),
		.kind           (kind),
		.source_irq     (source_irq),
		.gsi            (gsi),
		.override_flags (override_flags),
		.vector         (vector),
		.dest_id        (dest_id),
		.level_trigger  (level_trigger),
		.active_low     (active_low),
		.mask_on        (mask_on),
		.q_stat         (q_stat),
		.push           (push),
		.cmd            (push_cmd)
	);

	// The queue decouples command intake from the multi-cycle engine.
	irr_cmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	// Back end: override table, override search, enable sweep, routing, mask updates and reads.
	irr_back #(
		.OVERRIDE_DEPTH (OVERRIDE_DEPTH),
		.ENTRY_DEPTH    (ENTRY_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_stat   (q_stat),
		.pop      (pop),
		.gsi_base (gsi_base_q),
		.n_use    (n_use),
		.res_vld  (done),
		.res      (res)
	);

	assign status      = res.status;
	assign entry_index = res.entry_index;
	assign entry_low   = res.entry_low;
	assign entry_high  = res.entry_high;
	assign gsi_used    = res.gsi_used;

endmodule

/* verif/interrupt_redirection_router_tb.sv */
`timescale 1ns / 1ps

module interrupt_redirection_router_tb;
	import irr_pkg::*;

	// Geometry of the instance under test. The predictor uses the same numbers.
	localparam int OVR_DEPTH = 32;
	localparam int ENT_DEPTH = 24;

	// Redirection entry low word: the mask flag sits at bit 16.
	localparam int          MASK_POS     = 16;
	localparam logic [16:0] ENTRY_MASKED = 17'h1_0000;

	// Override flag codes that the package leaves unnamed. Code 0 conforms to the
	// bus default and code 2 is reserved; both keep the defaults of the bus type.
	localparam logic [1:0] FLAG_CONFORM  = 2'd0;
	localparam logic [1:0] FLAG_RESERVED = 2'd2;

	// Random commands per phase, idle cycles before a register update, and the
	// number of cycles without any transfer after which the run is declared hung.
	localparam int ITEMS_PER_PHASE = 186;
	localparam int NUM_PHASES      = 7;
	localparam int PAUSE_CYCLES    = 64;
	localparam int STALL_LIMIT     = 3000;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] source_irq;
		logic [9:0] gsi;
		logic [3:0] override_flags;
		logic [7:0] vector;
		logic [7:0] dest_id;
		logic       level_trigger;
		logic       active_low;
		logic       mask_on;
	} router_cmd_t;

	// Clock, reset and every input of the block start at known values.
	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        start          = 1'b0;
	logic [2:0]  kind           = KIND_CLEAR;
	logic [7:0]  source_irq     = '0;
	logic [9:0]  gsi            = '0;
	logic [3:0]  override_flags = '0;
	logic [7:0]  vector         = '0;
	logic [7:0]  dest_id        = '0;
	logic        level_trigger  = 1'b0;
	logic        active_low     = 1'b0;
	logic        mask_on        = 1'b0;
	logic        psel           = 1'b0;
	logic        penable        = 1'b0;
	logic        pwrite         = 1'b0;
	logic [2:0]  paddr          = '0;
	logic [31:0] pwdata         = '0;

	logic        busy;
	logic        done;
	logic [2:0]  status;
	logic [7:0]  entry_index;
	logic [16:0] entry_low;
	logic [31:0] entry_high;
	logic [9:0]  gsi_used;
	logic [31:0] prdata;
	logic        pready;

	interrupt_redirection_router #(
		.OVERRIDE_DEPTH(OVR_DEPTH),
		.ENTRY_DEPTH   (ENT_DEPTH)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.kind          (kind),
		.source_irq    (source_irq),
		.gsi           (gsi),
		.override_flags(override_flags),
		.vector        (vector),
		.dest_id       (dest_id),
		.level_trigger (level_trigger),
		.active_low    (active_low),
		.mask_on       (mask_on),
		.done          (done),
		.status        (status),
		.entry_index   (entry_index),
		.entry_low     (entry_low),
		.entry_high    (entry_high),
		.gsi_used      (gsi_used),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the block: register values, override table and redirection
	// table. It is advanced once per accepted command transfer, in order.
	logic [9:0]  cfg_base  = GSI_BASE_RESET;
	logic [8:0]  cfg_count = ENTRY_COUNT_RESET;
	logic [7:0]  ovr_src [OVR_DEPTH];
	logic [9:0]  ovr_gsi [OVR_DEPTH];
	logic [3:0]  ovr_flg [OVR_DEPTH];
	int          ovr_count = 0;
	logic        tbl_ready = 1'b0;
	logic [16:0] red_low  [ENT_DEPTH];
	logic [7:0]  red_dest [ENT_DEPTH];

	// Entries that hold a defined value from some enable. Mask and read commands
	// are steered away from any other entry, since its content is undefined.
	bit entry_known [ENT_DEPTH];

	router_cmd_t cmd_backlog [$];
	irr_result_t results_due [$];
	router_cmd_t launched;
	int          gap_left     = 0;
	bit          gaps_on      = 1'b1;
	int          mismatches   = 0;
	int unsigned stall_cycles = 0;
	irr_result_t want;

	// An entry count of zero, or any count beyond the table depth, means the whole table.
	function automatic int live_entries();
		if (cfg_count == 9'd0 || cfg_count > ENT_DEPTH)
			return ENT_DEPTH;
		return int'(cfg_count);
	endfunction

	// Table slot served by a global interrupt number, or -1 when out of range.
	function automatic int gsi_slot(logic [9:0] g);
		if (g < cfg_base)
			return -1;
		if (int'(g) - int'(cfg_base) >= live_entries())
			return -1;
		return int'(g) - int'(cfg_base);
	endfunction

	// The first matching override wins, so duplicates behind it are shadowed.
	function automatic int find_override(logic [7:0] irq);
		for (int i = 0; i < ovr_count; i++)
			if (ovr_src[i] == irq)
				return i;
		return -1;
	endfunction

	// Common tail of all three route commands: readiness, vector, then range.
	// A successful route leaves the entry unmasked.
	function automatic irr_result_t program_entry(logic [9:0] g, logic [7:0] vec,
			logic [7:0] dest, logic level, logic low);
		irr_result_t r;
		int slot;
		r = '0;
		r.gsi_used = g;
		slot = gsi_slot(g);
		if (!tbl_ready) begin
			r.status = ST_NOT_READY;
		end else if (vec < MIN_VECTOR) begin
			r.status = ST_VEC_LOW;
		end else if (slot < 0) begin
			r.status = ST_RANGE;
		end else begin
			red_low[slot]  = {1'b0, level, 1'b0, low, 5'b0, vec};
			red_dest[slot] = dest;
			r.status      = ST_OK;
			r.entry_index = 8'(slot);
			r.entry_low   = red_low[slot];
			r.entry_high  = {dest, 24'h0};
		end
		return r;
	endfunction

	// Result that one command produces, with the shadow state updated behind it.
	function automatic irr_result_t router_predict(router_cmd_t c);
		irr_result_t r;
		int k;
		int slot;
		logic [9:0] tg;
		logic lvl;
		logic low;
		r = '0;
		case (c.kind)
			KIND_CLEAR: begin
				ovr_count = 0;
			end
			KIND_ADD: begin
				if (ovr_count >= OVR_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					ovr_src[ovr_count] = c.source_irq;
					ovr_gsi[ovr_count] = c.gsi;
					ovr_flg[ovr_count] = c.override_flags;
					ovr_count++;
				end
			end
			KIND_ENABLE: begin
				for (int i = 0; i < live_entries(); i++) begin
					red_low[i]  = ENTRY_MASKED;
					red_dest[i] = '0;
				end
				tbl_ready = 1'b1;
			end
			KIND_ROUTE_GSI: begin
				r = program_entry(c.gsi, c.vector, c.dest_id, c.level_trigger, c.active_low);
			end
			KIND_ROUTE_ISA: begin
				// ISA sources default to active high, edge triggered.
				tg  = {2'b00, c.source_irq};
				lvl = 1'b0;
				low = 1'b0;
				k = find_override(c.source_irq);
				if (k >= 0) begin
					tg  = ovr_gsi[k];
					low = (ovr_flg[k][1:0] == FLAG_LOW_LEVEL);
					lvl = (ovr_flg[k][3:2] == FLAG_LOW_LEVEL);
				end
				r = program_entry(tg, c.vector, c.dest_id, lvl, low);
			end
			KIND_ROUTE_PCI: begin
				// PCI lines default to active low, level triggered. Readiness and the
				// line check come before the lookup and report no gsi.
				if (!tbl_ready) begin
					r.status = ST_NOT_READY;
				end else if (c.source_irq == 8'd0 || c.source_irq == PCI_LINE_NONE ||
						c.source_irq > MAX_PCI_LINE) begin
					r.status = ST_NO_PCI;
				end else begin
					tg  = {2'b00, c.source_irq};
					lvl = 1'b1;
					low = 1'b1;
					k = find_override(c.source_irq);
					if (k >= 0) begin
						tg = ovr_gsi[k];
						if (ovr_flg[k][1:0] == FLAG_HIGH_EDGE)
							low = 1'b0;
						else if (ovr_flg[k][1:0] == FLAG_LOW_LEVEL)
							low = 1'b1;
						if (ovr_flg[k][3:2] == FLAG_HIGH_EDGE)
							lvl = 1'b0;
						else if (ovr_flg[k][3:2] == FLAG_LOW_LEVEL)
							lvl = 1'b1;
					end
					r = program_entry(tg, c.vector, c.dest_id, lvl, low);
				end
			end
			default: begin
				// Set mask and read entry: the mask is a read-modify-write of one bit.
				r.gsi_used = c.gsi;
				slot = gsi_slot(c.gsi);
				if (!tbl_ready) begin
					r.status = ST_NOT_READY;
				end else if (slot < 0) begin
					r.status = ST_RANGE;
				end else begin
					if (c.kind == KIND_SET_MASK)
						red_low[slot][MASK_POS] = c.mask_on;
					r.status      = ST_OK;
					r.entry_index = 8'(slot);
					r.entry_low   = red_low[slot];
					r.entry_high  = {red_dest[slot], 24'h0};
				end
			end
		endcase
		return r;
	endfunction

	function automatic router_cmd_t make_cmd(logic [2:0] k, logic [7:0] irq, logic [9:0] g,
			logic [3:0] fl, logic [7:0] vec, logic [7:0] dest, logic lvl, logic low,
			logic mon);
		return {k, irq, g, fl, vec, dest, lvl, low, mon};
	endfunction

	// Appends a command to the backlog. The generator runs ahead of the block but
	// sees the same register values, so it can track which entries hold defined data.
	function automatic void queue_cmd(router_cmd_t c);
		int slot;
		if (c.kind == KIND_ENABLE)
			for (int i = 0; i < live_entries(); i++)
				entry_known[i] = 1'b1;
		if (c.kind == KIND_SET_MASK || c.kind == KIND_READ) begin
			slot = gsi_slot(c.gsi);
			if (slot >= 0 && !entry_known[slot])
				c.gsi = (cfg_base != '0) ? cfg_base - 10'd1 : 10'(cfg_base + live_entries());
		end
		cmd_backlog.push_back(c);
	endfunction

	// In fill mode, add requests dominate and the table is never cleared, so the
	// override table runs full. Otherwise the mix favors routes, masks and reads.
	function automatic logic [2:0] pick_kind(bit fill);
		int r;
		r = $urandom_range(0, 99);
		if (fill)
			r = (r < 40) ? 5 : 15 + (r - 40) * 85 / 60;
		if (r < 3)  return KIND_CLEAR;
		if (r < 15) return KIND_ADD;
		if (r < 20) return KIND_ENABLE;
		if (r < 40) return KIND_ROUTE_GSI;
		if (r < 55) return KIND_ROUTE_ISA;
		if (r < 70) return KIND_ROUTE_PCI;
		if (r < 85) return KIND_SET_MASK;
		return KIND_READ;
	endfunction

	// Mostly inside the window of entries in use, some just outside either end.
	function automatic logic [9:0] pick_gsi();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75) return 10'(cfg_base + $urandom_range(0, live_entries() - 1));
		if (r < 82) return cfg_base - 10'd1;
		if (r < 90) return 10'(cfg_base + live_entries());
		return 10'($urandom);
	endfunction

	// Legal ISA and PCI lines, where overrides are loaded, with some invalid lines.
	function automatic logic [7:0] pick_irq();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return 8'($urandom_range(0, MAX_PCI_LINE));
		if (r < 80) begin
			case ($urandom_range(0, 2))
				0:       return 8'd0;
				1:       return PCI_LINE_NONE;
				default: return MAX_PCI_LINE + 8'd1;
			endcase
		end
		return 8'($urandom);
	endfunction

	function automatic logic [7:0] pick_vec();
		if ($urandom_range(0, 99) < 88)
			return 8'($urandom_range(MIN_VECTOR, 255));
		return 8'($urandom_range(0, MIN_VECTOR - 1));
	endfunction

	// Idle cycles between two command transfers: mostly none or a few, rarely long.
	function automatic int next_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!gaps_on || r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic bit all_drained();
		return cmd_backlog.size() == 0 && !start && results_due.size() == 0;
	endfunction

	function automatic void check_field(string name, logic [31:0] exp_val, logic [31:0] got);
		if (got !== exp_val) begin
			$display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, exp_val, got);
			mismatches++;
		end
	endfunction

	// Command driver. A transfer happens at an edge where start is high and busy is
	// low; the expected result is worked out right then, in transfer order. While
	// busy holds the command off, start and the payload stay where they are.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				results_due.push_back(router_predict(launched));
			if (start && busy) begin
				// Held: the block has no room for this command yet.
			end else if (gap_left > 0) begin
				gap_left = gap_left - 1;
				start <= 1'b0;
			end else if (cmd_backlog.size() > 0) begin
				launched = cmd_backlog.pop_front();
				kind           <= launched.kind;
				source_irq     <= launched.source_irq;
				gsi            <= launched.gsi;
				override_flags <= launched.override_flags;
				vector         <= launched.vector;
				dest_id        <= launched.dest_id;
				level_trigger  <= launched.level_trigger;
				active_low     <= launched.active_low;
				mask_on        <= launched.mask_on;
				start          <= 1'b1;
				gap_left = next_gap();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Result monitor. done marks one cycle; the result is taken at the edge ending it
	// and checked field by field against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (results_due.size() == 0) begin
				$display("%0t: result with none expected: status %0d index %0d gsi %0d",
					$time, status, entry_index, gsi_used);
				mismatches++;
			end else begin
				want = results_due.pop_front();
				check_field("status", want.status, status);
				check_field("entry_index", want.entry_index, entry_index);
				check_field("entry_low", want.entry_low, entry_low);
				check_field("entry_high", want.entry_high, entry_high);
				check_field("gsi_used", want.gsi_used, gsi_used);
			end
		end
	end

	// Watchdog: any command transfer, result or register write restarts the count.
	always @(posedge clk) begin
		if ((start && !busy) || done || (psel && penable && pready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
			$display("interrupt_redirection_router_tb: FAIL");
			$finish;
		end
	end

	// Register write over the configuration port: a setup cycle, then an access
	// cycle that completes at the first edge with pready high. The shadow copy of
	// the register follows at that edge.
	task automatic write_reg(logic idx, logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_GSI_BASE)
			cfg_base = value[9:0];
		else
			cfg_count = value[8:0];
	endtask

	// Waits until every queued command is through and its result has been checked.
	task automatic wait_drained();
		while (!all_drained())
			@(posedge clk);
		repeat (PAUSE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int base_val;
		int count_val;
		bit fill;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed commands under the reset register values (base 0, 24 entries).
		// Every read and route before the enable must report not ready, including a PCI route.
		queue_cmd(make_cmd(KIND_READ, 8'd0, 10'd0, 4'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0));
		queue_cmd(make_cmd(KIND_ROUTE_GSI, 8'd0, 10'd5, 4'd0, 8'h40, 8'd1, 1'b1, 1'b0, 1'b0));
		queue_cmd(make_cmd(KIND_ROUTE_PCI, 8'd5, 10'd0, 4'd0, 8'h40, 8'd1, 1'b0, 1'b0, 1'b0));
		queue_cmd(make_cmd(KIND_ROUTE_ISA, 8'd4, 10'd0, 4'd0, 8'h40, 8'd1, 1'b0, 1'b0, 1'b0));
		// Overrides: low/level, high/edge, a shadowed duplicate, a reserved code.
		queue_cmd(make_cmd(KIND_ADD, 8'd9, 10'd9, {FLAG_LOW_LEVEL, FLAG_LOW_LEVEL},
			8'd0, 8'd0, 1'b0, 1'b0, 1'b0));
		queue_cmd(make_cmd(KIND_ADD, 8'd5, 10'd20, {FLAG_HIGH_EDGE, FLAG_HIGH_EDGE},
			8'd0, 8'd0, 1'b0, 1'b0, 1'b0));
		queue_cmd(make_cmd(KIND_ADD, 8'd9, 10'd30, {FLAG_CONFORM, FLAG_CONFORM},
			8'd0, 8'd0, 1'b0, 1'b0, 1'b0));
		queue_cmd(make_cmd(KIND_ADD, 8'hFF, 10'd1023, {FLAG_RESERVED, FLAG_RESERVED},
			8'd0, 8'd0, 1'b0, 1'b0, 1'b0));
		queue_cmd(make_cmd(KIND_ENABLE, 8'd0, 10'd0, 4'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0));
		// Route by gsi: lowest legal vector, all-ones fields, vector one too low,
		// first gsi past the table and the top of the gsi range.
		queue_cmd(make_cmd(KIND_ROUTE_GSI, 8'd0, 10'd0, 4'd0, MIN_VECTOR, 8'd0,
			1'b0, 1'b0, 1'b0));
		queue_cmd(make_cmd(KIND_ROUTE_GSI, 8'hFF, 10'd23, 4'hF, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1));
		queue_cmd(make_cmd(KIND_ROUTE_GSI, 8'd0, 10'd7, 4'd0, MIN_VECTOR - 8'd1, 8'd3,
			1'b0, 1'b0, 1'b0));
		queue_cmd(make_cmd(KIND_ROUTE_GSI, 8'd0, 10'd24, 4'd0, 8'h80, 8'd3, 1'b0, 1'b0, 1'b0));
		queue_cmd(make_cmd(KIND_ROUTE_GSI, 8'd0, 10'd1023, 4'd0, 8'h80, 8'd3, 1'b0, 1'b0, 1'b0));
		// ISA: the first of the two irq 9 overrides applies; irq 3 has none.
		queue_cmd(make_cmd(KIND_ROUTE_ISA, 8'd9, 10'd0, 4'd0, 8'h51, 8'h12, 1'b0, 1'b0, 1'b0));
		queue_cmd(make_cmd(KIND_ROUTE_ISA, 8'd3, 10'd0, 4'd0, 8'h52, 8'h13, 1'b0, 1'b0, 1'b0));
		// PCI: line zero, no line, first line past the limit, then valid lines.
		queue_cmd(make_cmd(KIND_ROUTE_PCI, 8'd0, 10'd0, 4'd0, 8'h60, 8'h20, 1'b0, 1'b0, 1'b0));
		queue_cmd(make_cmd(KIND_ROUTE_PCI, PCI_LINE_NONE, 10'd0, 4'd0, 8'h60, 8'h20,
			1'b0, 1'b0, 1'b0));
		queue_cmd(make_cmd(KIND_ROUTE_PCI, MAX_PCI_LINE + 8'd1, 10'd0, 4'd0, 8'h60, 8'h20,
			1'b0, 1'b0, 1'b0));
		queue_cmd(make_cmd(KIND_ROUTE_PCI, 8'd5, 10'd0, 4'd0, 8'h61, 8'h21, 1'b0, 1'b0, 1'b0));
		queue_cmd(make_cmd(KIND_ROUTE_PCI, MAX_PCI_LINE, 10'd0, 4'd0, 8'h62, 8'h22,
			1'b0, 1'b0, 1'b0));
		// Mask and unmask a routed entry, read an entry still masked by the enable.
		queue_cmd(make_cmd(KIND_SET_MASK, 8'd0, 10'd23, 4'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b1));
		queue_cmd(make_cmd(KIND_SET_MASK, 8'd0, 10'd23, 4'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0));
		queue_cmd(make_cmd(KIND_READ, 8'd0, 10'd11, 4'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0));
		// Clearing keeps readiness; irq 9 then routes by default.
		queue_cmd(make_cmd(KIND_CLEAR, 8'd0, 10'd0, 4'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0));
		queue_cmd(make_cmd(KIND_ROUTE_ISA, 8'd9, 10'd0, 4'd0, 8'h53, 8'h14, 1'b0, 1'b0, 1'b0));

		// Random phases. Each but the first starts from an idle block with new
		// register values, covering both ends of the base and a count of one, zero
		// (whole table) and far past the depth (clamped).
		for (int p = 0; p < NUM_PHASES; p++) begin
			fill = 1'b0;
			gaps_on = 1'b1;
			base_val = 0;
			count_val = 24;
			case (p)
				1: count_val = 1;
				2: begin
					base_val = 1023;
					count_val = 256;
				end
				3: count_val = 0;
				4: begin
					base_val = 17;
					count_val = 511;
					fill = 1'b1;
				end
				5: begin
					base_val = $urandom_range(0, 1000);
					count_val = $urandom_range(1, ENT_DEPTH);
					gaps_on = 1'b0;
				end
				6: base_val = 500;
				default: ;
			endcase
			if (p > 0) begin
				wait_drained();
				write_reg(REG_GSI_BASE, 32'(base_val));
				write_reg(REG_ENTRY_COUNT, 32'(count_val));
				repeat (2) @(posedge clk);
				if ($urandom_range(0, 2) != 0)
					queue_cmd(make_cmd(KIND_ENABLE, 8'($urandom), 10'($urandom), 4'($urandom),
						8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom),
						1'($urandom)));
			end
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				queue_cmd(make_cmd(pick_kind(fill), pick_irq(), pick_gsi(), 4'($urandom),
					pick_vec(), 8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom)));
		end

		wait_drained();
		if (mismatches == 0 && results_due.size() == 0)
			$display("interrupt_redirection_router_tb: PASS");
		else
			$display("interrupt_redirection_router_tb: FAIL");
		$finish;
	end

endmodule
